// ----- rtl/icp_pkg.sv -----
`default_nettype none

package icp_pkg;

    localparam int COUNT_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int MAX_BITS  = 16;
    localparam int PAL_BITS  = 2;
    localparam int ADDR_BITS = 3;
    localparam int DATA_BITS = 32;
    localparam int KMUL_BITS = 13;

    typedef logic [23:0] t_rgb;
    typedef logic [7:0]  t_chan;

    localparam logic [MAX_BITS-1:0] MAX_RESET = 16'd100;
    localparam logic [PAL_BITS-1:0] PAL_RESET = 2'd1;

    localparam logic [PAL_BITS-1:0] PAL_BLUE_WHITE   = 2'd1;
    localparam logic [PAL_BITS-1:0] PAL_RED_YELLOW   = 2'd2;
    localparam logic [PAL_BITS-1:0] PAL_PURPLE_GREEN = 2'd3;

    localparam logic REG_MAX_ITER = 1'b0;
    localparam logic REG_PALETTE  = 1'b1;

    localparam logic [KMUL_BITS-1:0] K_NINE           = 13'd2295;
    localparam logic [KMUL_BITS-1:0] K_FIFTEEN        = 13'd3825;
    localparam logic [KMUL_BITS-1:0] K_TWO_EIGHT_HALF = 13'd4335;
    localparam logic [7:0]           K_FULL           = 8'd255;
    localparam logic [6:0]           K_BLUE_RAMP      = 7'd100;
    localparam t_rgb                 BLACK_PIXEL      = 24'h000000;

endpackage

`default_nettype wire

// ----- rtl/iteration_count_palette_top.sv -----
`default_nettype none

// Iteration-count palette: turns one escape count per beat into a packed
// 24-bit RGB pixel (red 23:16, green 15:8, blue 7:0). A new count may enter
// every clock while o_stall is low. Each count passes through the fraction
// divider, which resolves one quotient bit per pipeline stage, followed by
// two multiply stages, a combine stage and the constant-scaling output
// register. Stalls collapse bubbles: a stage holds only while it is full and
// the stage after it cannot take its beat. Counts at or above the iteration
// limit (register 0, byte address 0) come out black; palette_select (register
// 1, byte address 4) picks 1 blue-white, 2 red-yellow or 3 purple-green, with
// code 0 drawn as purple-green. Write the registers only while no beats are
// in flight.

module iteration_count_palette_top #(
    parameter int COUNT_BITS    = icp_pkg::COUNT_BITS_DEF,
    parameter int FRACTION_BITS = icp_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,

    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic [COUNT_BITS-1:0]            i_iteration_count,

    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output icp_pkg::t_rgb                         o_pixel_rgb,

    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [icp_pkg::ADDR_BITS-1:0]    paddr,
    input  wire logic [icp_pkg::DATA_BITS-1:0]    pwdata,
    output logic      [icp_pkg::DATA_BITS-1:0]    prdata,
    output logic                                  pready
);

    localparam int FB     = FRACTION_BITS;
    localparam int MB     = icp_pkg::MAX_BITS;
    localparam int CW     = (COUNT_BITS > MB) ? COUNT_BITS : MB;
    localparam int PW     = 4 * FB;
    localparam int XW     = PW + icp_pkg::KMUL_BITS;
    localparam int G2W    = 2 * FB + 8;
    localparam int B2W    = FB + 8;
    localparam int ST_M1  = FB;
    localparam int ST_M2  = FB + 1;
    localparam int ST_M3  = FB + 2;
    localparam int ST_OUT = FB + 3;
    localparam int NS     = FB + 4;

    logic [MB-1:0]                 r_max;
    logic [icp_pkg::PAL_BITS-1:0]  r_pal;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= icp_pkg::MAX_RESET;
            r_pal <= icp_pkg::PAL_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                icp_pkg::REG_MAX_ITER: r_max <= pwdata[MB-1:0];
                icp_pkg::REG_PALETTE:  r_pal <= pwdata[icp_pkg::PAL_BITS-1:0];
                default:               r_max <= r_max;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            icp_pkg::REG_MAX_ITER: prdata = icp_pkg::DATA_BITS'(r_max);
            icp_pkg::REG_PALETTE:  prdata = icp_pkg::DATA_BITS'(r_pal);
            default:               prdata = '0;
        endcase
    end

    // stage valids and advance chain
    logic [NS-1:0] r_vld;
    logic [NS-1:0] w_adv;

    assign w_adv[NS-1] = !r_vld[NS-1] || !i_stall;
    for (genvar k = 0; k < NS - 1; k++) begin : g_adv
        assign w_adv[k] = !r_vld[k] || w_adv[k+1];
    end

    assign o_stall = !w_adv[0];
    assign o_valid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // restoring divider, one quotient bit per stage
    logic [MB-1:0] r_rem [FB];
    logic [FB-1:0] r_quo [FB];
    logic          r_blk [FB];

    for (genvar k = 0; k < FB; k++) begin : g_div
        logic [MB-1:0] w_rem_in;
        logic [FB-1:0] w_quo_in;
        logic          w_blk_in;
        logic [MB:0]   w_dbl;
        logic [MB:0]   w_sub;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_rem_in = MB'(i_iteration_count);
            assign w_quo_in = '0;
            assign w_blk_in = CW'(i_iteration_count) >= CW'(r_max);
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_quo_in = r_quo[k-1];
            assign w_blk_in = r_blk[k-1];
        end

        assign w_dbl = {w_rem_in, 1'b0};
        assign w_sub = w_dbl - {1'b0, r_max};
        assign w_ge  = w_dbl >= {1'b0, r_max};

        always_ff @(posedge i_clk) begin
            if (w_adv[k]) begin
                r_rem[k] <= w_ge ? w_sub[MB-1:0] : w_dbl[MB-1:0];
                r_quo[k] <= {w_quo_in[FB-2:0], w_ge};
                r_blk[k] <= w_blk_in;
            end
        end
    end

    // square and cross terms of t and u = 1 - t
    logic [FB-1:0]   w_t;
    logic [FB-1:0]   w_u;
    logic [2*FB-1:0] r_t2;
    logic [2*FB-1:0] r_tu;
    logic [2*FB-1:0] r_u2;
    logic [FB-1:0]   r_t1;
    logic            r_blk1;

    assign w_t = r_quo[FB-1];
    assign w_u = FB'(0) - w_t;

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_M1]) begin
            r_t2   <= (2*FB)'(w_t) * (2*FB)'(w_t);
            r_tu   <= (2*FB)'(w_t) * (2*FB)'(w_u);
            r_u2   <= (2*FB)'(w_u) * (2*FB)'(w_u);
            r_t1   <= w_t;
            r_blk1 <= r_blk[FB-1];
        end
    end

    // fourth-degree terms as half-width partial products
    logic [3*FB-1:0]     r_p1_lo;
    logic [3*FB-1:0]     r_p1_hi;
    logic [3*FB-1:0]     r_p2_lo;
    logic [3*FB-1:0]     r_p2_hi;
    logic [3*FB-1:0]     r_p3_lo;
    logic [3*FB-1:0]     r_p3_hi;
    logic [G2W-1:0]      w_g2_prod;
    logic [B2W-1:0]      w_b2_prod;
    icp_pkg::t_chan      r_g2;
    icp_pkg::t_chan      r_b2;
    logic                r_blk2;

    assign w_g2_prod = G2W'(r_t2) * G2W'(icp_pkg::K_FULL);
    assign w_b2_prod = B2W'(r_t1) * B2W'(icp_pkg::K_BLUE_RAMP);

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_M2]) begin
            r_p1_lo <= (3*FB)'(r_tu) * (3*FB)'(r_t2[FB-1:0]);
            r_p1_hi <= (3*FB)'(r_tu) * (3*FB)'(r_t2[2*FB-1:FB]);
            r_p2_lo <= (3*FB)'(r_tu) * (3*FB)'(r_tu[FB-1:0]);
            r_p2_hi <= (3*FB)'(r_tu) * (3*FB)'(r_tu[2*FB-1:FB]);
            r_p3_lo <= (3*FB)'(r_tu) * (3*FB)'(r_u2[FB-1:0]);
            r_p3_hi <= (3*FB)'(r_tu) * (3*FB)'(r_u2[2*FB-1:FB]);
            r_g2    <= w_g2_prod[2*FB+7:2*FB];
            r_b2    <= w_b2_prod[FB+7:FB];
            r_blk2  <= r_blk1;
        end
    end

    // combine partials, route terms to channels
    logic [PW-1:0]   w_p1;
    logic [PW-1:0]   w_p2;
    logic [PW-1:0]   w_p3;
    logic [PW-1:0]   r_pr;
    logic [PW-1:0]   r_pg;
    logic [PW-1:0]   r_pb;
    icp_pkg::t_chan  r_g3;
    icp_pkg::t_chan  r_b3;
    logic            r_blk3;
    logic            w_pal1;

    assign w_p1   = PW'(r_p1_lo) + (PW'(r_p1_hi) << FB);
    assign w_p2   = PW'(r_p2_lo) + (PW'(r_p2_hi) << FB);
    assign w_p3   = PW'(r_p3_lo) + (PW'(r_p3_hi) << FB);
    assign w_pal1 = (r_pal == icp_pkg::PAL_BLUE_WHITE);

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_M3]) begin
            r_pr   <= w_pal1 ? w_p1 : w_p3;
            r_pg   <= w_p2;
            r_pb   <= w_pal1 ? w_p3 : w_p1;
            r_g3   <= r_g2;
            r_b3   <= r_b2;
            r_blk3 <= r_blk2;
        end
    end

    // scale by palette constants and pack
    logic [XW-1:0]   w_r_prod;
    logic [XW-1:0]   w_g15_prod;
    logic [XW-1:0]   w_g17_prod;
    logic [XW-1:0]   w_b17_prod;
    logic [XW-1:0]   w_b9_prod;
    icp_pkg::t_rgb   n_pix;
    icp_pkg::t_rgb   r_pix;

    assign w_r_prod   = XW'(r_pr) * XW'(icp_pkg::K_NINE);
    assign w_g15_prod = XW'(r_pg) * XW'(icp_pkg::K_FIFTEEN);
    assign w_g17_prod = XW'(r_pg) * XW'(icp_pkg::K_TWO_EIGHT_HALF);
    assign w_b17_prod = XW'(r_pb) * XW'(icp_pkg::K_TWO_EIGHT_HALF);
    assign w_b9_prod  = XW'(r_pb) * XW'(icp_pkg::K_NINE);

    always_comb begin
        case (r_pal)
            icp_pkg::PAL_BLUE_WHITE: begin
                n_pix = {w_r_prod[PW+7:PW], w_g15_prod[PW+7:PW], w_b17_prod[PW+8:PW+1]};
            end
            icp_pkg::PAL_RED_YELLOW: begin
                n_pix = {icp_pkg::K_FULL, r_g3, r_b3};
            end
            default: begin
                n_pix = {w_r_prod[PW+7:PW], w_g17_prod[PW+8:PW+1], w_b9_prod[PW+7:PW]};
            end
        endcase
        if (r_blk3) begin
            n_pix = icp_pkg::BLACK_PIXEL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_OUT]) begin
            r_pix <= n_pix;
        end
    end

    assign o_pixel_rgb = r_pix;

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int LATENCY     = icp_pkg::FRACTION_BITS_DEF + 4;
    localparam int LIMIT       = 1000000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 155;
    localparam int PRESSURE_PH = 5;
    localparam int PLAN_LEN    = 31;

    localparam logic [icp_pkg::ADDR_BITS-1:0] ADDR_MAX_ITER = {icp_pkg::REG_MAX_ITER, 2'b00};
    localparam logic [icp_pkg::ADDR_BITS-1:0] ADDR_PALETTE  = {icp_pkg::REG_PALETTE, 2'b00};
    localparam logic [icp_pkg::PAL_BITS-1:0]  PAL_CODE_ZERO = 2'd0;

    typedef enum logic [1:0] {
        ROW_COUNT,
        ROW_SET_MAX,
        ROW_SET_PAL
    } t_row_kind;

    typedef struct packed {
        t_row_kind      kind;
        logic [15:0]    value;
        logic           known;
        icp_pkg::t_rgb  pixel;
    } t_plan_row;

    typedef struct packed {
        logic [15:0]    count;
        icp_pkg::t_rgb  pixel;
    } t_pending_pixel;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_valid;
    logic                            o_stall;
    logic [15:0]                     i_iteration_count;
    logic                            o_valid;
    logic                            i_stall;
    icp_pkg::t_rgb                   o_pixel_rgb;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [icp_pkg::ADDR_BITS-1:0]   paddr;
    logic [icp_pkg::DATA_BITS-1:0]   pwdata;
    logic [icp_pkg::DATA_BITS-1:0]   prdata;
    logic                            pready;

    logic [icp_pkg::MAX_BITS-1:0]    max_cfg;
    logic [icp_pkg::PAL_BITS-1:0]    pal_cfg;
    t_pending_pixel                  pixel_q[$];
    bit                              hold_req;
    int                              cycles;
    int                              errors;
    int                              counts_sent;
    int                              pixels_checked;
    int                              settings_used;
    int                              held_cycles;

    t_plan_row plan [PLAN_LEN] = '{
        '{ROW_COUNT,   16'd0,     1'b1, 24'h000000},
        '{ROW_COUNT,   16'd50,    1'b1, 24'h8FEF87},
        '{ROW_COUNT,   16'd99,    1'b0, 24'h000000},
        '{ROW_COUNT,   16'd1,     1'b0, 24'h000000},
        '{ROW_COUNT,   16'd100,   1'b1, 24'h000000},
        '{ROW_COUNT,   16'd65535, 1'b1, 24'h000000},
        '{ROW_SET_PAL, 16'd2,     1'b0, 24'h000000},
        '{ROW_COUNT,   16'd0,     1'b1, 24'hFF0000},
        '{ROW_COUNT,   16'd50,    1'b1, 24'hFF3F32},
        '{ROW_COUNT,   16'd99,    1'b0, 24'h000000},
        '{ROW_SET_PAL, 16'd3,     1'b0, 24'h000000},
        '{ROW_COUNT,   16'd50,    1'b1, 24'h8F878F},
        '{ROW_COUNT,   16'd1,     1'b0, 24'h000000},
        '{ROW_SET_PAL, 16'd0,     1'b0, 24'h000000},
        '{ROW_COUNT,   16'd50,    1'b1, 24'h8F878F},
        '{ROW_COUNT,   16'd98,    1'b0, 24'h000000},
        '{ROW_SET_MAX, 16'd65535, 1'b0, 24'h000000},
        '{ROW_COUNT,   16'd65534, 1'b0, 24'h000000},
        '{ROW_COUNT,   16'd65535, 1'b1, 24'h000000},
        '{ROW_COUNT,   16'd32768, 1'b0, 24'h000000},
        '{ROW_COUNT,   16'h5555,  1'b0, 24'h000000},
        '{ROW_SET_PAL, 16'd1,     1'b0, 24'h000000},
        '{ROW_COUNT,   16'hAAAA,  1'b0, 24'h000000},
        '{ROW_SET_MAX, 16'd1,     1'b0, 24'h000000},
        '{ROW_COUNT,   16'd0,     1'b1, 24'h000000},
        '{ROW_COUNT,   16'd1,     1'b1, 24'h000000},
        '{ROW_SET_PAL, 16'd2,     1'b0, 24'h000000},
        '{ROW_COUNT,   16'd0,     1'b1, 24'hFF0000},
        '{ROW_SET_MAX, 16'd0,     1'b0, 24'h000000},
        '{ROW_COUNT,   16'd0,     1'b1, 24'h000000},
        '{ROW_COUNT,   16'd65535, 1'b1, 24'h000000}
    };

    iteration_count_palette_top i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_iteration_count (i_iteration_count),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_pixel_rgb       (o_pixel_rgb),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("%0t: timeout with %0d pixels outstanding", $realtime, pixel_q.size());
            $display("iteration_count_palette_top: mismatch");
            $finish;
        end
    end

    // floor(k * a * b * c * d / 2^sh), low 8 bits
    function automatic icp_pkg::t_chan bernstein_term(
            input logic [icp_pkg::KMUL_BITS-1:0] k,
            input logic [16:0] a, input logic [16:0] b,
            input logic [16:0] c, input logic [16:0] d,
            input int sh);
        logic [127:0] prod;
        prod = 128'(k);
        prod = prod * 128'(a);
        prod = prod * 128'(b);
        prod = prod * 128'(c);
        prod = prod * 128'(d);
        prod = prod >> sh;
        return prod[7:0];
    endfunction

    function automatic icp_pkg::t_rgb paint_pixel(input logic [15:0] count);
        logic [31:0]    quot;
        logic [16:0]    t;
        logic [16:0]    u;
        logic [63:0]    wide;
        icp_pkg::t_chan r;
        icp_pkg::t_chan g;
        icp_pkg::t_chan b;
        if (count >= max_cfg)
            return icp_pkg::BLACK_PIXEL;
        quot = {count, 16'h0000} / 32'(max_cfg);
        t    = quot[16:0];
        u    = 17'h10000 - t;
        case (pal_cfg)
            icp_pkg::PAL_BLUE_WHITE: begin
                r = bernstein_term(icp_pkg::K_NINE, u, t, t, t, 64);
                g = bernstein_term(icp_pkg::K_FIFTEEN, u, u, t, t, 64);
                b = bernstein_term(icp_pkg::K_TWO_EIGHT_HALF, u, u, u, t, 65);
            end
            icp_pkg::PAL_RED_YELLOW: begin
                r    = icp_pkg::K_FULL;
                wide = 64'(t) * 64'(t) * 64'(icp_pkg::K_FULL);
                wide = wide >> 32;
                g    = wide[7:0];
                wide = 64'(t) * 64'(icp_pkg::K_BLUE_RAMP);
                wide = wide >> 16;
                b    = wide[7:0];
            end
            default: begin
                r = bernstein_term(icp_pkg::K_NINE, t, u, u, u, 64);
                g = bernstein_term(icp_pkg::K_TWO_EIGHT_HALF, t, t, u, u, 65);
                b = bernstein_term(icp_pkg::K_NINE, t, t, t, u, 64);
            end
        endcase
        return {r, g, b};
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        else if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic drive_count(input logic [15:0] count, input int gap, input logic known,
                               input icp_pkg::t_rgb pixel);
        t_pending_pixel entry;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_iteration_count <= count;
        do @(posedge i_clk); while (o_stall);
        entry.count = count;
        entry.pixel = known ? pixel : paint_pixel(count);
        pixel_q.push_back(entry);
        counts_sent++;
    endtask

    task automatic drain_pipe();
        i_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [icp_pkg::ADDR_BITS-1:0] addr,
                             input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'h0000, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_MAX_ITER)
            max_cfg = value;
        else if (addr == ADDR_PALETTE)
            pal_cfg = value[icp_pkg::PAL_BITS-1:0];
        settings_used++;
        @(posedge i_clk);
    endtask

    // receiver side: random stalls, plus one long hold-off on request
    initial begin
        int len;
        int n;
        int roll;
        forever begin
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) begin
                    @(posedge i_clk);
                    held_cycles++;
                end
                hold_req = 1'b0;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 45) begin
                    i_stall <= 1'b0;
                    len = $urandom_range(1, 30);
                end else if (roll < 90) begin
                    i_stall <= 1'b1;
                    len = $urandom_range(1, 3);
                end else begin
                    i_stall <= 1'b1;
                    len = $urandom_range(10, 50);
                end
                n = 0;
                do begin
                    @(posedge i_clk);
                    n++;
                end while (n < len && !hold_req);
            end
        end
    end

    always @(posedge i_clk) begin
        t_pending_pixel head;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pixel_q.size() == 0) begin
                $display("%0t: unexpected pixel beat, expected none got %06h",
                         $realtime, o_pixel_rgb);
                errors++;
            end else begin
                head = pixel_q.pop_front();
                pixels_checked++;
                if (o_pixel_rgb !== head.pixel) begin
                    $display("%0t: pixel_rgb for count %0d expected %06h got %06h",
                             $realtime, head.count, head.pixel, o_pixel_rgb);
                    errors++;
                end
            end
        end
    end

    initial begin
        logic [15:0] count;
        logic [15:0] lim;
        int          roll;
        cycles         = 0;
        errors         = 0;
        counts_sent    = 0;
        pixels_checked = 0;
        settings_used  = 0;
        held_cycles    = 0;
        hold_req       = 1'b0;
        max_cfg        = icp_pkg::MAX_RESET;
        pal_cfg        = icp_pkg::PAL_RESET;

        i_rst_n           <= 1'b0;
        i_valid           <= 1'b0;
        i_iteration_count <= '0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < PLAN_LEN; i++) begin
            case (plan[i].kind)
                ROW_COUNT: drive_count(plan[i].value, pick_gap(), plan[i].known, plan[i].pixel);
                ROW_SET_MAX: begin
                    drain_pipe();
                    apb_write(ADDR_MAX_ITER, plan[i].value);
                end
                default: begin
                    drain_pipe();
                    apb_write(ADDR_PALETTE, plan[i].value);
                end
            endcase
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_pipe();
            case (ph)
                0: lim = 16'hFFFF;
                1: lim = 16'd1;
                default: begin
                    roll = $urandom_range(0, 7);
                    case (roll)
                        0: lim = 16'd0;
                        1: lim = 16'd1;
                        2: lim = 16'hFFFF;
                        3: lim = 16'd2;
                        4, 5: lim = 16'($urandom_range(1, 300));
                        default: lim = 16'($urandom_range(1, 65535));
                    endcase
                end
            endcase
            apb_write(ADDR_MAX_ITER, lim);
            apb_write(ADDR_PALETTE,
                      16'($urandom_range(PAL_CODE_ZERO, icp_pkg::PAL_PURPLE_GREEN)));
            if (ph == PRESSURE_PH)
                hold_req = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                roll = $urandom_range(0, 9);
                if (roll < 8 && max_cfg != 0)
                    count = 16'($urandom_range(0, max_cfg - 1));
                else if (roll < 9)
                    count = 16'($urandom);
                else
                    count = (max_cfg > 16'd65533) ? 16'hFFFF
                                                  : 16'(max_cfg + $urandom_range(0, 2));
                drive_count(count, (ph == PRESSURE_PH) ? 0 : pick_gap(), 1'b0,
                            icp_pkg::BLACK_PIXEL);
            end
        end

        i_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (2 * LATENCY) @(posedge i_clk);

        $display("%0d counts driven, %0d pixels compared over %0d register writes",
                 counts_sent, pixels_checked, settings_used);
        $display("receiver held off %0d cycles in one stretch; %0d errors",
                 held_cycles, errors);
        if (errors == 0)
            $display("iteration_count_palette_top: match");
        else
            $display("iteration_count_palette_top: mismatch");
        $finish;
    end

endmodule
